// File: hw/rtl/lj_pkg.sv
// shared types, constants and fixed-point helpers of the lennard-jones pair kernel
// no dependencies; imported by lennard_jones_pair_kernel
package lj_pkg;

  // divider geometry: numerators are 62-bit, the squared distance keeps 46 bits
  localparam int DIV_NW      = 62;
  localparam int DIV_DW      = 46;
  localparam int R0_W        = 34;
  localparam int POST_STAGES = 11;
  localparam int OUT_TDATA_W = 240;

  localparam logic [63:0] CAP       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TWO_Q32   = 64'h0000_0002_0000_0000;
  localparam logic [63:0] FAR_LIMIT = 64'h0000_0000_4000_0000;
  localparam logic [63:0] CAP_D2    = CAP / 2;
  localparam logic [63:0] CAP_D4    = CAP / 4;
  localparam logic [63:0] CAP_D12   = CAP / 12;
  localparam logic [63:0] CAP_D24   = CAP / 24;
  localparam logic [63:0] Q_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] Q_NEG_LIM = 64'h0000_8000_0000_0000;

  localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] OUT_MIN = 48'sh8000_0000_0000;

  // pair modes
  localparam logic [1:0] MODE_EXCLUDED = 2'd0;
  localparam logic [1:0] MODE_FULL     = 2'd1;
  localparam logic [1:0] MODE_HALVED   = 2'd2;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_RADIUS_RULE     = 1'b0,
    REG_GRADIENT_ENABLE = 1'b1
  } lj_reg_t;

  // partial products of one 64x64 q.32 multiply
  typedef struct packed {
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [31:0] ll;
  } lj_pp_t;

  function automatic lj_pp_t mulq_pp(logic [63:0] a, logic [63:0] b);
    lj_pp_t p;
    logic [63:0] all;
    p.hh = 64'(a[63:32]) * 64'(b[63:32]);
    p.hl = 64'(a[63:32]) * 64'(b[31:0]);
    p.lh = 64'(a[31:0]) * 64'(b[63:32]);
    all  = 64'(a[31:0]) * 64'(b[31:0]);
    p.ll = all[63:32];
    return p;
  endfunction

  // sum of partials, capped at the largest positive value
  function automatic logic [63:0] mulq_fin(lj_pp_t p);
    logic [65:0] acc;
    acc = (66'(p.hh[30:0]) << 32) + 66'(p.hl) + 66'(p.lh) + 66'(p.ll);
    if (p.hh >= 64'h8000_0000) return CAP;
    if (acc > 66'(CAP)) return CAP;
    return acc[63:0];
  endfunction

  function automatic logic [63:0] cap_x2(logic [63:0] a);
    return (a > CAP_D2) ? CAP : (a << 1);
  endfunction

  function automatic logic [63:0] cap_x4(logic [63:0] a);
    return (a > CAP_D4) ? CAP : (a << 2);
  endfunction

  function automatic logic [63:0] cap_x12(logic [63:0] a);
    return (a > CAP_D12) ? CAP : ((a << 3) + (a << 2));
  endfunction

  function automatic logic [63:0] cap_x24(logic [63:0] a);
    return (a > CAP_D24) ? CAP : ((a << 4) + (a << 3));
  endfunction

  // q.32 magnitude to signed q23.24, with optional halving
  function automatic logic signed [47:0] sat_q32(logic [63:0] mag, logic neg, logic half);
    logic [63:0] m;
    logic [63:0] q;
    m = half ? (mag >> 1) : mag;
    q = m >> 8;
    if (neg) return (q >= Q_NEG_LIM) ? OUT_MIN : -$signed(q[47:0]);
    return (q > Q_POS_MAX) ? OUT_MAX : $signed(q[47:0]);
  endfunction

endpackage

// File: hw/rtl/lennard_jones_pair_kernel.sv
// lennard-jones 12-6 pair kernel: energy, gradient and batch energy sum per atom pair
// depends on lj_pkg and lj_div
//
// Usage
//   in_*  : one atom pair per beat; tdata holds first_x/y/z, second_x/y/z,
//           both radii, both depths and pair_mode; tlast marks the last pair of a batch.
//   out_* : one result per pair, in order; tdata holds pair_energy, grad_x/y/z and
//           batch_energy; tlast marks the result that ends the batch.
//   cfg_* : register writes (index 0 radius rule, index 1 gradient enable), always ready;
//           write only while no pair is in flight.
// Throughput is one pair per cycle while the receiver keeps up. A pair passes 77 registers: 3 front
// stages (difference, squares, distance), 62 stages of the bit-per-stage dividers for the reduced
// radius ratio and the unit vector, 11 stages of the capped q.32 multiply chain and the output register.
// All stages move together; when the receiver stalls a waiting result, the whole pipe
// holds and in_tready drops in the same cycle, so nothing is lost or repeated.
// Reset clears every valid bit and the batch energy sum, radius rule goes to 0 and
// gradient enable to 1.
module lennard_jones_pair_kernel #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, first_radius,
  // second_radius, first_depth, second_depth, pair_mode, zero fill
  input  logic [((6*COORD_WIDTH+66+7)/8)*8-1:0]        in_tdata,
  input  logic                                         in_tlast,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // pair_energy, grad_x, grad_y, grad_z, batch_energy
  output logic [lj_pkg::OUT_TDATA_W-1:0]               out_tdata,
  output logic                                         out_tlast,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic                                         cfg_index,
  input  logic                                         cfg_data
);
  import lj_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PARAM_BASE = 6 * CW;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              half;
    logic              zero_res;
    logic              contact;
    logic              grad_on;
    logic              rule;
    logic [2:0]        dx_neg;
    logic [2:0]        dx_zero;
    logic [2:0][29:0]  ax;
    logic [2:0][59:0]  sq;
    logic [DIV_DW-1:0] r2h;
    logic [R0_W-1:0]   r0sq;
    logic [31:0]       prod;
  } lj_front_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic        half;
    logic        zero_res;
    logic        contact;
    logic        r0_nz;
    logic        grad_on;
    logic        rule;
    logic [2:0]  dx_neg;
    logic [2:0]  dx_zero;
    logic [31:0] sq_v;
    logic [15:0] root;
  } lj_side_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             half;
    logic             zero_res;
    logic             contact;
    logic             live;
    logic             grad_on;
    logic             rule;
    logic [2:0]       dx_neg;
    logic [2:0]       dx_zero;
    logic [63:0]      s;
    logic [63:0]      eps32;
    logic [2:0][63:0] u;
    logic [63:0]      ss;
    logic [63:0]      rr;
    logic [63:0]      dmag;
    logic             e_neg;
    logic [63:0]      gd;
    logic             fneg;
    logic [63:0]      er;
    logic [63:0]      emag;
    logic [63:0]      gm;
    logic [63:0]      gf;
    logic [2:0][63:0] gmag;
    lj_pp_t [2:0]     pp;
  } lj_post_t;

  logic adv;
  logic radius_rule_r;
  logic gradient_enable_r;
  logic signed [47:0] energy_sum_r;

  lj_front_t f_nxt [3];
  lj_front_t f_r   [3];
  lj_side_t  side_in;
  lj_side_t  sb_src [DIV_NW];
  lj_side_t  sb_nxt [DIV_NW];
  lj_side_t  sb_r   [DIV_NW];
  lj_post_t  p_nxt  [POST_STAGES];
  lj_post_t  p_r    [POST_STAGES];
  lj_post_t  p_last;

  logic [DIV_NW-1:0] num_s;
  logic [DIV_NW-1:0] quo_s;
  logic [DIV_NW-1:0] num_u [3];
  logic [DIV_NW-1:0] quo_u [3];

  logic signed [47:0] e_fin;
  logic signed [47:0] g_fin [3];
  logic signed [47:0] sum_fin;

  logic                          out_tvalid_r;
  logic [OUT_TDATA_W-1:0]        out_tdata_r;
  logic                          out_tlast_r;

  // the whole pipe moves unless a result waits on a stalled receiver
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_rule_r     <= 1'b0;
      gradient_enable_r <= 1'b1;
    end else if (cfg_valid) begin
      case (lj_reg_t'(cfg_index))
        REG_RADIUS_RULE:     radius_rule_r     <= cfg_data;
        REG_GRADIENT_ENABLE: gradient_enable_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front stage 0: differences, magnitudes, far test, radius and depth products
  always_comb begin
    logic [CW-1:0]      fst;
    logic [CW-1:0]      sec;
    logic signed [CW:0] dxv;
    logic [CW:0]        axv;
    logic [63:0]        ax64;
    logic               far_v;
    logic [15:0]        ra;
    logic [15:0]        rb;
    logic [16:0]        rsum;
    logic [1:0]         mode;
    f_nxt[0] = '0;
    far_v    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      fst  = in_tdata[i*CW +: CW];
      sec  = in_tdata[(3+i)*CW +: CW];
      dxv  = $signed({sec[CW-1], sec}) - $signed({fst[CW-1], fst});
      axv  = dxv[CW] ? (CW+1)'(-dxv) : (CW+1)'(dxv);
      ax64 = 64'(axv);
      if (ax64 >= FAR_LIMIT) far_v = 1'b1;
      f_nxt[0].dx_neg[i]  = dxv[CW];
      f_nxt[0].dx_zero[i] = (dxv == '0);
      f_nxt[0].ax[i]      = ax64[29:0];
    end
    ra   = in_tdata[PARAM_BASE +: 16];
    rb   = in_tdata[PARAM_BASE+16 +: 16];
    rsum = 17'(ra) + 17'(rb);
    mode = in_tdata[PARAM_BASE+64 +: 2];
    f_nxt[0].valid    = in_tvalid;
    f_nxt[0].last     = in_tlast;
    f_nxt[0].half     = mode[1];
    f_nxt[0].zero_res = (mode == MODE_EXCLUDED) || far_v;
    f_nxt[0].grad_on  = gradient_enable_r;
    f_nxt[0].rule     = radius_rule_r;
    f_nxt[0].r0sq     = radius_rule_r ? (R0_W'(rsum) * R0_W'(rsum))
                                      : (R0_W'(ra) * R0_W'(rb));
    f_nxt[0].prod     = 32'(in_tdata[PARAM_BASE+32 +: 16]) *
                        32'(in_tdata[PARAM_BASE+48 +: 16]);
  end

  // front stage 1: squared differences
  always_comb begin
    f_nxt[1] = f_r[0];
    for (int i = 0; i < 3; i++) begin
      f_nxt[1].sq[i] = 60'(f_r[0].ax[i]) * 60'(f_r[0].ax[i]);
    end
  end

  // front stage 2: squared distance in q.16
  always_comb begin
    logic [61:0] r2;
    f_nxt[2] = f_r[1];
    r2 = 62'(f_r[1].sq[0]) + 62'(f_r[1].sq[1]) + 62'(f_r[1].sq[2]);
    f_nxt[2].r2h     = r2[61:16];
    f_nxt[2].contact = (r2[61:16] == '0);
  end

  for (genvar k = 0; k < 3; k++) begin : g_front
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        f_r[k].valid <= 1'b0;
      end else if (adv) begin
        f_r[k] <= f_nxt[k];
      end
    end
  end

  // divider operands: radius ratio and the three unit-vector components
  assign num_s = {4'b0, f_r[2].r0sq, 24'b0};

  lj_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_s (
    .clk (clk),
    .en  (adv),
    .num (num_s),
    .den (f_r[2].r2h),
    .quo (quo_s)
  );

  for (genvar i = 0; i < 3; i++) begin : g_udiv
    assign num_u[i] = {f_r[2].ax[i], 32'b0};

    lj_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_u (
      .clk (clk),
      .en  (adv),
      .num (num_u[i]),
      .den (f_r[2].r2h),
      .quo (quo_u[i])
    );
  end

  // side band alongside the dividers; the depth root is found one bit a stage
  always_comb begin
    side_in          = '0;
    side_in.valid    = f_r[2].valid;
    side_in.last     = f_r[2].last;
    side_in.half     = f_r[2].half;
    side_in.zero_res = f_r[2].zero_res;
    side_in.contact  = f_r[2].contact;
    side_in.r0_nz    = (f_r[2].r0sq != '0);
    side_in.grad_on  = f_r[2].grad_on;
    side_in.rule     = f_r[2].rule;
    side_in.dx_neg   = f_r[2].dx_neg;
    side_in.dx_zero  = f_r[2].dx_zero;
    side_in.sq_v     = f_r[2].prod;
  end

  for (genvar k = 0; k < DIV_NW; k++) begin : g_side
    if (k == 0) begin : g_first
      assign sb_src[k] = side_in;
    end else begin : g_next
      assign sb_src[k] = sb_r[k-1];
    end

    if (k < 16) begin : g_root
      localparam logic [15:0] RBIT = 16'h8000 >> k;
      always_comb begin
        logic [15:0] t;
        t         = sb_src[k].root | RBIT;
        sb_nxt[k] = sb_src[k];
        if (32'(t) * 32'(t) <= sb_src[k].sq_v) sb_nxt[k].root = t;
      end
    end else begin : g_pass
      assign sb_nxt[k] = sb_src[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r[k].valid <= 1'b0;
      end else if (adv) begin
        sb_r[k] <= sb_nxt[k];
      end
    end
  end

  // post stage 0: gather quotients, first partial products of s*s
  always_comb begin
    p_nxt[0]          = '0;
    p_nxt[0].valid    = sb_r[DIV_NW-1].valid;
    p_nxt[0].last     = sb_r[DIV_NW-1].last;
    p_nxt[0].half     = sb_r[DIV_NW-1].half;
    p_nxt[0].zero_res = sb_r[DIV_NW-1].zero_res;
    p_nxt[0].contact  = sb_r[DIV_NW-1].contact;
    p_nxt[0].live     = sb_r[DIV_NW-1].r0_nz && (sb_r[DIV_NW-1].root != '0);
    p_nxt[0].grad_on  = sb_r[DIV_NW-1].grad_on;
    p_nxt[0].rule     = sb_r[DIV_NW-1].rule;
    p_nxt[0].dx_neg   = sb_r[DIV_NW-1].dx_neg;
    p_nxt[0].dx_zero  = sb_r[DIV_NW-1].dx_zero;
    p_nxt[0].s        = 64'(quo_s);
    p_nxt[0].eps32    = {32'b0, sb_r[DIV_NW-1].root, 16'b0};
    for (int i = 0; i < 3; i++) begin
      p_nxt[0].u[i] = 64'(quo_u[i]);
    end
    p_nxt[0].pp[0]    = mulq_pp(64'(quo_s), 64'(quo_s));
  end

  // post stages 1..10: capped multiply chain, split into partials and sums
  for (genvar k = 1; k < POST_STAGES; k++) begin : g_post
    always_comb begin
      logic [63:0] ref_v;
      logic [63:0] t_v;
      ref_v    = '0;
      t_v      = '0;
      p_nxt[k] = p_r[k-1];
      case (k)
        1: p_nxt[k].ss = mulq_fin(p_r[k-1].pp[0]);
        2: p_nxt[k].pp[0] = mulq_pp(p_r[k-1].ss, p_r[k-1].s);
        3: p_nxt[k].rr = mulq_fin(p_r[k-1].pp[0]);
        4: begin
          // energy and force brackets around the reduced ratio
          ref_v = p_r[k-1].rule ? TWO_Q32 : ONE_Q32;
          t_v   = p_r[k-1].rule ? p_r[k-1].rr : cap_x2(p_r[k-1].rr);
          p_nxt[k].pp[0] = mulq_pp(p_r[k-1].eps32, p_r[k-1].rr);
          p_nxt[k].e_neg = (p_r[k-1].rr < ref_v);
          p_nxt[k].dmag  = (p_r[k-1].rr >= ref_v) ? (p_r[k-1].rr - ref_v)
                                                  : (ref_v - p_r[k-1].rr);
          p_nxt[k].fneg  = (t_v > ONE_Q32);
          p_nxt[k].gd    = (t_v >= ONE_Q32) ? (t_v - ONE_Q32) : (ONE_Q32 - t_v);
        end
        5: p_nxt[k].er = mulq_fin(p_r[k-1].pp[0]);
        6: begin
          p_nxt[k].pp[0] = mulq_pp(p_r[k-1].er, p_r[k-1].dmag);
          p_nxt[k].pp[1] = mulq_pp(p_r[k-1].er, p_r[k-1].gd);
        end
        7: begin
          p_nxt[k].emag = mulq_fin(p_r[k-1].pp[0]);
          p_nxt[k].gm   = mulq_fin(p_r[k-1].pp[1]);
        end
        8: begin
          p_nxt[k].emag = p_r[k-1].rule ? p_r[k-1].emag : cap_x4(p_r[k-1].emag);
          p_nxt[k].gf   = p_r[k-1].rule ? cap_x12(p_r[k-1].gm) : cap_x24(p_r[k-1].gm);
        end
        9: begin
          for (int i = 0; i < 3; i++) begin
            p_nxt[k].pp[i] = mulq_pp(p_r[k-1].gf, p_r[k-1].u[i]);
          end
        end
        10: begin
          for (int i = 0; i < 3; i++) begin
            p_nxt[k].gmag[i] = mulq_fin(p_r[k-1].pp[i]);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < POST_STAGES; k++) begin : g_post_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_r[k].valid <= 1'b0;
      end else if (adv) begin
        p_r[k] <= p_nxt[k];
      end
    end
  end

  assign p_last = p_r[POST_STAGES-1];

  // final selection: excluded, far, contact or regular result
  always_comb begin
    logic signed [48:0] acc;
    e_fin = '0;
    for (int i = 0; i < 3; i++) g_fin[i] = '0;
    if (!p_last.zero_res) begin
      if (p_last.contact) begin
        if (p_last.live) begin
          e_fin = OUT_MAX;
          for (int i = 0; i < 3; i++) begin
            if (p_last.grad_on && !p_last.dx_zero[i]) begin
              g_fin[i] = p_last.dx_neg[i] ? OUT_MAX : OUT_MIN;
            end
          end
        end
      end else begin
        e_fin = sat_q32(p_last.emag, p_last.e_neg, p_last.half);
        for (int i = 0; i < 3; i++) begin
          if (p_last.grad_on) begin
            g_fin[i] = sat_q32(p_last.gmag[i], p_last.dx_neg[i] != p_last.fneg, p_last.half);
          end
        end
      end
    end
    // saturating batch sum
    acc = {energy_sum_r[47], energy_sum_r} + {e_fin[47], e_fin};
    if (acc[48] != acc[47]) begin
      sum_fin = acc[48] ? OUT_MIN : OUT_MAX;
    end else begin
      sum_fin = acc[47:0];
    end
  end

  // output register and batch sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      energy_sum_r <= '0;
    end else if (adv) begin
      out_tvalid_r <= p_last.valid;
      if (p_last.valid) begin
        energy_sum_r <= p_last.last ? '0 : sum_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {sum_fin, g_fin[2], g_fin[1], g_fin[0], e_fin};
      out_tlast_r <= p_last.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef ASSERT_OFF
  // the batch sum is clear right after the closing pair leaves
  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    adv && p_last.valid && p_last.last |=> energy_sum_r == '0)
    else $error("batch sum not cleared after last pair");

  // excluded or far pairs give zero energy and gradient
  a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
    adv && p_last.valid && p_last.zero_res |=> out_tdata_r[191:0] == '0)
    else $error("excluded or far pair gave nonzero result");

  // gradient disabled gives zero gradients
  a_grad_off: assert property (@(posedge clk) disable iff (!rst_n)
    adv && p_last.valid && !p_last.grad_on |=> out_tdata_r[191:48] == '0)
    else $error("gradient output while disabled");

  // a stalled result keeps the batch sum still
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(energy_sum_r))
    else $error("batch sum moved during stall");
`endif

endmodule

// File: hw/rtl/lj_div.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; used by lennard_jones_pair_kernel
module lj_div #(
  parameter int NW = 62,
  parameter int DW = 46
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] n_src [NW];
  logic [DW-1:0] r_src [NW];
  logic [DW-1:0] d_src [NW];
  logic [NW-1:0] q_src [NW];
  logic [NW-1:0] n_r   [NW];
  logic [DW-1:0] r_r   [NW];
  logic [DW-1:0] d_r   [NW];
  logic [NW-1:0] q_r   [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    // stage input: ports for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign n_src[k] = num;
      assign r_src[k] = '0;
      assign d_src[k] = den;
      assign q_src[k] = '0;
    end else begin : g_next
      assign n_src[k] = n_r[k-1];
      assign r_src[k] = r_r[k-1];
      assign d_src[k] = d_r[k-1];
      assign q_src[k] = q_r[k-1];
    end

    // shift in one numerator bit and try the subtraction
    assign trial = {r_src[k], n_src[k][NW-1]};
    assign ge    = (trial >= {1'b0, d_src[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_src[k] << 1;
        r_r[k] <= ge ? DW'(trial - {1'b0, d_src[k]}) : trial[DW-1:0];
        d_r[k] <= d_src[k];
        q_r[k] <= {q_src[k][NW-2:0], ge};
      end
    end
  end

  assign quo = q_r[NW-1];

endmodule
